FILE: src/sab_pkg.sv
`timescale 1ns / 1ps
package sab_pkg;
    localparam int MAX_LEN_DEF  = 512;
    localparam int ALPHABET_DEF = 32;
    localparam int SYM_W        = 5;
    localparam int QLEN_W       = 10;

    typedef enum logic [0:0] {
        OP_APPEND = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QRD,
        ST_QWAIT,
        ST_QLEN,
        ST_QRES,
        ST_A_START,
        ST_A_RDT,
        ST_A_CHK,
        ST_A_RDL,
        ST_A_NEXTP,
        ST_A_RDQ,
        ST_A_CMPQ,
        ST_C_RDQL,
        ST_C_CP_RD,
        ST_C_CP_WR,
        ST_C_RDT,
        ST_C_CHK,
        ST_C_RDL,
        ST_C_NEXTP,
        ST_A_DONE
    } state_t;
endpackage

FILE: src/sab_trans_mem.sv
`timescale 1ns / 1ps
// Transition table: one write port, one registered read port.
module sab_trans_mem #(
    parameter int AW = 15,
    parameter int DW = 10
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [0:(1<<AW)-1];

    // Write, and a registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: src/sab_node_mem.sv
`timescale 1ns / 1ps
// Per-state length and suffix link store, one write port per column and one shared read port.
module sab_node_mem #(
    parameter int AW = 10,
    parameter int DW = 10
) (
    input  logic          clk,
    input  logic          len_we,
    input  logic          lnk_we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] len_wdata,
    input  logic [AW-1:0] lnk_waddr,
    input  logic [AW-1:0] lnk_wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] len_rdata,
    output logic [AW-1:0] lnk_rdata
);
    logic [DW-1:0] len_mem [0:(1<<AW)-1];
    logic [AW-1:0] lnk_mem [0:(1<<AW)-1];

    // Length column
    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[waddr] <= len_wdata;
        end
        len_rdata <= len_mem[raddr];
    end

    // Link column
    always_ff @(posedge clk)
    begin
        if (lnk_we)
        begin
            lnk_mem[lnk_waddr] <= lnk_wdata;
        end
        lnk_rdata <= lnk_mem[raddr];
    end
endmodule

FILE: src/suffix_automaton_builder_unit.sv
`timescale 1ns / 1ps
// Online suffix automaton builder. An append request (opcode 0) extends the
// string by one symbol and returns nothing; a query request (opcode 1) returns
// suffix_is_unique. After reset the block sweeps the transition memory clear,
// one entry per cycle (all 2^(state bits + symbol bits) entries, 32768 by
// default) before it takes any request. A query steps through QRD, QWAIT,
// QLEN and QRES and then registers its result; no new request is taken until
// that result is accepted. An append runs a first walk along the suffix links
// and, when a state is cloned, a row copy one alphabet entry at a time through
// the transition memory, followed by a redirect walk. Appends past MAX_LEN
// symbols or with a symbol at or above ALPHABET are dropped.
module suffix_automaton_builder_unit #(
    parameter int MAX_LEN  = sab_pkg::MAX_LEN_DEF,
    parameter int ALPHABET = sab_pkg::ALPHABET_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      opcode,
    input  logic [sab_pkg::SYM_W-1:0] symbol,
    input  logic [sab_pkg::QLEN_W-1:0] query_length,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      suffix_is_unique
);
    localparam int NST  = 2 * MAX_LEN;
    localparam int SW   = $clog2(NST);
    localparam int AB   = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int TAW  = SW + AB;
    localparam int LW   = $clog2(MAX_LEN + 1);
    localparam int QW   = sab_pkg::QLEN_W;

    sab_pkg::state_t st_reg, st_next;

    logic [TAW-1:0] clr_reg, clr_next;
    logic [SW-1:0]  last_reg, last_next;
    logic [SW-1:0]  cnt_reg, cnt_next;
    logic [LW-1:0]  curlen_reg, curlen_next;
    logic [SW-1:0]  p_reg, p_next;
    logic [SW-1:0]  q_reg, q_next;
    logic [SW-1:0]  cur_reg, cur_next;
    logic [SW-1:0]  cl_reg, cl_next;
    logic [LW-1:0]  plen_reg, plen_next;
    logic [AB-1:0]  sym_reg, sym_next;
    logic [AB-1:0]  col_reg, col_next;
    logic [QW-1:0]  ql_reg, ql_next;
    logic           res_reg, res_next;
    logic           ov_reg, ov_next;

    logic           t_we;
    logic [TAW-1:0] t_waddr, t_raddr;
    logic [SW-1:0]  t_wdata, t_rdata;
    logic           len_we, lnk_we;
    logic [SW-1:0]  n_waddr, n_raddr, lk_waddr, lk_wdata, lk_rdata;
    logic [LW-1:0]  len_wdata, len_rdata;

    sab_trans_mem #(.AW(TAW), .DW(SW)) u_trans (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    sab_node_mem #(.AW(SW), .DW(LW)) u_node (
        .clk(clk), .len_we(len_we), .lnk_we(lnk_we), .waddr(n_waddr),
        .len_wdata(len_wdata), .lnk_waddr(lk_waddr), .lnk_wdata(lk_wdata),
        .raddr(n_raddr), .len_rdata(len_rdata), .lnk_rdata(lk_rdata)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= sab_pkg::ST_CLEAR;
            clr_reg    <= '0;
            last_reg   <= '0;
            cnt_reg    <= '0;
            curlen_reg <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            clr_reg    <= clr_next;
            last_reg   <= last_next;
            cnt_reg    <= cnt_next;
            curlen_reg <= curlen_next;
            ov_reg     <= ov_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        q_reg    <= q_next;
        cur_reg  <= cur_next;
        cl_reg   <= cl_next;
        plen_reg <= plen_next;
        sym_reg  <= sym_next;
        col_reg  <= col_next;
        ql_reg   <= ql_next;
        res_reg  <= res_next;
    end

    assign in_ready         = (st_reg == sab_pkg::ST_IDLE) && !ov_reg;
    assign out_valid        = ov_reg;
    assign suffix_is_unique = res_reg;

    // Next state, memory control
    always_comb
    begin
        st_next     = st_reg;
        clr_next    = clr_reg;
        last_next   = last_reg;
        cnt_next    = cnt_reg;
        curlen_next = curlen_reg;
        p_next      = p_reg;
        q_next      = q_reg;
        cur_next    = cur_reg;
        cl_next     = cl_reg;
        plen_next   = plen_reg;
        sym_next    = sym_reg;
        col_next    = col_reg;
        ql_next     = ql_reg;
        res_next    = res_reg;
        ov_next     = ov_reg;
        t_we        = 1'b0;
        t_waddr     = {p_reg, sym_reg};
        t_wdata     = cur_reg;
        t_raddr     = {p_reg, sym_reg};
        len_we      = 1'b0;
        lnk_we      = 1'b0;
        n_waddr     = cur_reg;
        len_wdata   = LW'(curlen_reg + 1'b1);
        lk_waddr    = cur_reg;
        lk_wdata    = '0;
        n_raddr     = p_reg;

        // Drop the result once taken
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        unique case (st_reg)
            sab_pkg::ST_CLEAR:
            begin
                t_we    = 1'b1;
                t_waddr = clr_reg;
                t_wdata = '0;
                len_we  = 1'b1;
                n_waddr = '0;
                len_wdata = '0;
                clr_next = TAW'(clr_reg + 1'b1);
                if (clr_reg == TAW'((1 << TAW) - 1))
                begin
                    st_next = sab_pkg::ST_IDLE;
                end
            end
            sab_pkg::ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    sym_next = AB'(symbol);
                    ql_next  = query_length;
                    if (opcode == sab_pkg::OP_QUERY)
                    begin
                        st_next = sab_pkg::ST_QRD;
                    end
                    else if ((32'(symbol) < ALPHABET)
                             && (32'(curlen_reg) < MAX_LEN))
                    begin
                        st_next = sab_pkg::ST_A_START;
                    end
                end
            end
            // Query: read link of last, then its length
            sab_pkg::ST_QRD:
            begin
                n_raddr = last_reg;
                st_next = sab_pkg::ST_QWAIT;
            end
            sab_pkg::ST_QWAIT:
            begin
                n_raddr = lk_rdata;
                st_next = sab_pkg::ST_QLEN;
            end
            sab_pkg::ST_QLEN:
            begin
                plen_next = len_rdata;
                st_next   = sab_pkg::ST_QRES;
            end
            sab_pkg::ST_QRES:
            begin
                if (last_reg == '0)
                begin
                    res_next = (ql_reg != '0);
                end
                else
                begin
                    res_next = (32'(ql_reg) > 32'(plen_reg));
                end
                ov_next = 1'b1;
                st_next = sab_pkg::ST_IDLE;
            end
            // Append: allocate cur
            sab_pkg::ST_A_START:
            begin
                cur_next = SW'(cnt_reg + 1'b1);
                cnt_next = SW'(cnt_reg + 1'b1);
                p_next   = last_reg;
                len_we   = 1'b1;
                n_waddr  = SW'(cnt_reg + 1'b1);
                st_next  = sab_pkg::ST_A_RDT;
            end
            sab_pkg::ST_A_RDT:
            begin
                t_raddr = {p_reg, sym_reg};
                n_raddr = p_reg;
                st_next = sab_pkg::ST_A_CHK;
            end
            sab_pkg::ST_A_CHK:
            begin
                plen_next = len_rdata;
                if (t_rdata == '0)
                begin
                    t_we    = 1'b1;
                    if (p_reg == '0)
                    begin
                        lnk_we   = 1'b1;
                        lk_waddr = cur_reg;
                        lk_wdata = '0;
                        st_next  = sab_pkg::ST_A_DONE;
                    end
                    else
                    begin
                        q_next  = lk_rdata;
                        st_next = sab_pkg::ST_A_NEXTP;
                    end
                end
                else
                begin
                    q_next  = t_rdata;
                    st_next = sab_pkg::ST_A_RDQ;
                end
            end
            sab_pkg::ST_A_NEXTP:
            begin
                p_next  = q_reg;
                st_next = sab_pkg::ST_A_RDT;
            end
            sab_pkg::ST_A_RDQ:
            begin
                n_raddr = q_reg;
                st_next = sab_pkg::ST_A_CMPQ;
            end
            sab_pkg::ST_A_CMPQ:
            begin
                if (len_rdata == LW'(plen_reg + 1'b1))
                begin
                    lnk_we   = 1'b1;
                    lk_waddr = cur_reg;
                    lk_wdata = q_reg;
                    st_next  = sab_pkg::ST_A_DONE;
                end
                else
                begin
                    // Clone q
                    cl_next   = SW'(cnt_reg + 1'b1);
                    cnt_next  = SW'(cnt_reg + 1'b1);
                    len_we    = 1'b1;
                    n_waddr   = SW'(cnt_reg + 1'b1);
                    len_wdata = LW'(plen_reg + 1'b1);
                    lnk_we    = 1'b1;
                    lk_waddr  = SW'(cnt_reg + 1'b1);
                    lk_wdata  = lk_rdata;
                    col_next  = '0;
                    st_next   = sab_pkg::ST_C_RDQL;
                end
            end
            sab_pkg::ST_C_RDQL:
            begin
                lnk_we   = 1'b1;
                lk_waddr = q_reg;
                lk_wdata = cl_reg;
                st_next  = sab_pkg::ST_C_CP_RD;
            end
            // Copy row q to row cl
            sab_pkg::ST_C_CP_RD:
            begin
                t_raddr = {q_reg, col_reg};
                st_next = sab_pkg::ST_C_CP_WR;
            end
            sab_pkg::ST_C_CP_WR:
            begin
                t_we    = 1'b1;
                t_waddr = {cl_reg, col_reg};
                t_wdata = t_rdata;
                col_next = AB'(col_reg + 1'b1);
                if (32'(col_reg) == ALPHABET - 1)
                begin
                    lnk_we   = 1'b1;
                    lk_waddr = cur_reg;
                    lk_wdata = cl_reg;
                    st_next  = sab_pkg::ST_C_RDT;
                end
                else
                begin
                    st_next = sab_pkg::ST_C_CP_RD;
                end
            end
            // Redirect p walk to clone
            sab_pkg::ST_C_RDT:
            begin
                t_raddr = {p_reg, sym_reg};
                n_raddr = p_reg;
                st_next = sab_pkg::ST_C_CHK;
            end
            sab_pkg::ST_C_CHK:
            begin
                if (t_rdata == q_reg)
                begin
                    t_we    = 1'b1;
                    t_wdata = cl_reg;
                    if (p_reg == '0)
                    begin
                        st_next = sab_pkg::ST_A_DONE;
                    end
                    else
                    begin
                        p_next  = lk_rdata;
                        st_next = sab_pkg::ST_C_RDT;
                    end
                end
                else
                begin
                    st_next = sab_pkg::ST_A_DONE;
                end
            end
            sab_pkg::ST_A_DONE:
            begin
                last_next   = cur_reg;
                curlen_next = LW'(curlen_reg + 1'b1);
                st_next     = sab_pkg::ST_IDLE;
            end
            default:
            begin
                st_next = sab_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

FILE: tb/sv/suffix_automaton_builder_unit_test.sv
`timescale 1ns / 1ps
module suffix_automaton_builder_unit_test;
    localparam int MAXL   = sab_pkg::MAX_LEN_DEF;
    localparam int NSYM   = sab_pkg::ALPHABET_DEF;
    localparam int NST    = 2 * MAXL;

    typedef struct packed {
        logic                           opcode;
        logic [sab_pkg::SYM_W-1:0]      symbol;
        logic [sab_pkg::QLEN_W-1:0]     query_length;
        logic                           hold_until_drained;
    } request_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic opcode;
    logic [sab_pkg::SYM_W-1:0] symbol;
    logic [sab_pkg::QLEN_W-1:0] query_length;
    logic out_valid;
    logic out_ready;
    logic suffix_is_unique;

    suffix_automaton_builder_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .symbol(symbol),
        .query_length(query_length),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .suffix_is_unique(suffix_is_unique)
    );

    // automaton shadow used for prediction
    int unsigned sam_next [NST][NSYM];
    int unsigned sam_len  [NST];
    int unsigned sam_link [NST];
    int unsigned sam_last;
    int unsigned sam_count;

    request_t pending_requests[$];
    bit       expected_unique[$];
    int       error_count;
    int       appends_sent;
    int       queries_checked;
    int       clones_made;
    bit       stimulus_done;
    int       stall_long_left;
    bit       long_stall_req;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void sam_clear();
        for (int s = 0; s < NST; s++)
        begin
            sam_len[s] = 0;
            sam_link[s] = 0;
            for (int c = 0; c < NSYM; c++)
                sam_next[s][c] = 0;
        end
        sam_last = 0;
        sam_count = 0;
    endfunction

    function automatic void sam_extend(int unsigned sym);
        int unsigned cur, p, q, cl;
        bit alive;
        alive = 1'b1;
        if (sym >= NSYM || sam_len[sam_last] >= MAXL)
            return;
        cur = ++sam_count;
        sam_len[cur] = sam_len[sam_last] + 1;
        p = sam_last;
        while (alive && sam_next[p][sym] == 0)
        begin
            sam_next[p][sym] = cur;
            if (p == 0) alive = 1'b0;
            else p = sam_link[p];
        end
        if (!alive)
            sam_link[cur] = 0;
        else
        begin
            q = sam_next[p][sym];
            if (sam_len[q] == sam_len[p] + 1)
                sam_link[cur] = q;
            else
            begin
                cl = ++sam_count;
                clones_made++;
                sam_link[cl] = sam_link[q];
                for (int c = 0; c < NSYM; c++)
                    sam_next[cl][c] = sam_next[q][c];
                sam_len[cl] = sam_len[p] + 1;
                while (alive && sam_next[p][sym] == q)
                begin
                    sam_next[p][sym] = cl;
                    if (p == 0) alive = 1'b0;
                    else p = sam_link[p];
                end
                sam_link[cur] = cl;
                sam_link[q] = cl;
            end
        end
        sam_last = cur;
    endfunction

    function automatic bit sam_unique(int unsigned qlen);
        int unsigned rep;
        rep = (sam_last == 0) ? 0 : sam_len[sam_link[sam_last]];
        return qlen > rep;
    endfunction

    function automatic void push_append(int unsigned sym);
        request_t r;
        r = '0;
        r.opcode = sab_pkg::OP_APPEND;
        r.symbol = sym[sab_pkg::SYM_W-1:0];
        pending_requests.push_back(r);
    endfunction

    function automatic void push_query(int unsigned qlen, bit drain = 1'b0);
        request_t r;
        r = '0;
        r.opcode = sab_pkg::OP_QUERY;
        r.query_length = qlen[sab_pkg::QLEN_W-1:0];
        r.symbol = sab_pkg::SYM_W'($urandom);
        r.hold_until_drained = drain;
        pending_requests.push_back(r);
    endfunction

    // fill the request queue: directed part, then random strings with queries
    initial
    begin
        int unsigned alpha, plen;
        sam_clear();
        push_query(0);
        push_query(1);
        push_query(1023);
        push_append(31);
        push_append(0);
        push_append(0);
        push_query(0);
        push_query(1);
        push_query(2);
        push_append(0);
        push_append(31);
        push_append(0);
        push_append(0);
        push_query(2);
        push_query(3);
        push_query(512, 1'b1);
        push_append(5);
        push_append(10);
        push_append(5);
        push_append(10);
        push_query(2);
        push_query(3);
        push_query(4);
        for (int i = 0; i < 450; i++)
        begin
            if (i == 350)
                push_query($urandom_range(0, 1023), 1'b1);
            if ($urandom_range(0, 2) == 0)
                push_query($urandom_range(0, 1) ? $urandom_range(0, 12)
                                                : $urandom_range(0, 1023));
            else
            begin
                // small alphabets make repeats and clones common
                alpha = $urandom_range(0, 3) == 0 ? NSYM : $urandom_range(1, 3);
                if ($urandom_range(0, 4) == 0)
                begin
                    plen = $urandom_range(2, 6);
                    for (int k = 0; k < plen; k++)
                        push_append($urandom_range(0, alpha - 1));
                end
                else
                    push_append($urandom_range(0, alpha - 1));
            end
        end
        // run past the length limit, with queries after it
        for (int i = 0; i < 380; i++)
            push_append($urandom_range(0, 1));
        for (int i = 0; i < 10; i++)
        begin
            push_append($urandom_range(0, 31));
            push_query($urandom_range(0, 1023));
        end
        push_query(MAXL);
        push_query(0);
    end

    // reset and drive
    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        request_t r;
        bit fire;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode <= 1'b0;
            symbol <= '0;
            query_length <= '0;
            burst_left <= 0;
            gap_left <= 0;
            stimulus_done <= 1'b0;
            appends_sent <= 0;
        end
        else
        begin
            fire = in_valid && in_ready;
            if (fire)
            begin
                r = pending_requests.pop_front();
                if (r.opcode == sab_pkg::OP_QUERY)
                    expected_unique.push_back(sam_unique(r.query_length));
                else
                begin
                    sam_extend(r.symbol);
                    appends_sent <= appends_sent + 1;
                end
            end
            if (!in_valid || fire)
            begin
                if (pending_requests.size() == 0)
                begin
                    in_valid <= 1'b0;
                    stimulus_done <= 1'b1;
                end
                else if (pending_requests[0].hold_until_drained &&
                         (expected_unique.size() != 0 || out_valid))
                    in_valid <= 1'b0;
                else if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    r = pending_requests[0];
                    in_valid <= 1'b1;
                    opcode <= r.opcode;
                    symbol <= r.symbol;
                    query_length <= r.query_length;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off midway
    int stall_phase;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_phase <= 0;
            stall_long_left <= 0;
            long_stall_req <= 1'b0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (!long_stall_req && appends_sent >= 150)
            begin
                long_stall_req <= 1'b1;
                stall_long_left <= 3000;
                out_ready <= 1'b0;
            end
            else if (stall_long_left > 0)
            begin
                stall_long_left <= stall_long_left - 1;
                out_ready <= 1'b0;
            end
            else if ((stall_phase / 200) % 3 == 2)
                out_ready <= 1'b1;
            else
                out_ready <= ((stall_phase % 7) < 4) || ($urandom_range(0, 3) == 0);
        end
    end

    // check results against the oldest expectation
    always @(posedge clk)
    begin
        bit want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_unique.size() == 0)
            begin
                $error("suffix_is_unique: unexpected result %0b", suffix_is_unique);
                error_count++;
            end
            else
            begin
                want = expected_unique.pop_front();
                queries_checked++;
                if (suffix_is_unique !== want)
                begin
                    $error("suffix_is_unique: expected %0b actual %0b", want,
                           suffix_is_unique);
                    error_count++;
                end
            end
        end
    end

    // finish once everything has drained
    initial
    begin
        wait (rst_n === 1'b1);
        wait (stimulus_done && expected_unique.size() == 0);
        repeat (200) @(posedge clk);
        $display("Covered %0d appends (%0d clones, final length %0d), %0d queries checked",
                 appends_sent, clones_made, sam_len[sam_last], queries_checked);
        if (error_count == 0 && expected_unique.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
